@@ rtl/hkac_pkg.sv @@
// ----------------------------------------------------------------------------
// hkac_pkg
// shared widths, register codes, request types and table functions of the
// hard knee compressor
// ----------------------------------------------------------------------------
package hkac_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int LOG_TABLE_BITS = 8;
	localparam int MANT_BITS      = 31;   // q1.30 mantissa
	localparam int MANT_FRAC      = 30;
	localparam int POS_BITS       = $clog2(SAMPLE_BITS);
	localparam int OCT_FRAC       = 16;   // octave levels in q.16
	localparam int LVL_BITS       = 24;
	localparam int SHIFT_BITS     = LVL_BITS - OCT_FRAC;
	localparam int DIV_BITS       = 26;
	localparam int DIV_STEP       = 2;
	localparam int DIV_STAGES     = DIV_BITS / DIV_STEP;
	localparam int RATIO_BITS     = 10;
	localparam int THR_BITS       = 16;
	localparam int GAIN_BITS      = 14;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CONV_BITS      = 24;
	localparam int RATIO_SHIFT    = 4;    // ratio is in 1/16 steps

	localparam logic [RATIO_BITS-1:0] RATIO_MIN = RATIO_BITS'(16);
	localparam logic [RATIO_BITS-1:0] RATIO_MAX = RATIO_BITS'(512);

	// 1/256 dB to q.16 octaves, scaled by 2^16
	localparam logic signed [CONV_BITS-1:0] DB_TO_OCT = CONV_BITS'(2786635);

	localparam logic signed [LVL_BITS-1:0] LVL_OFFSET =
		LVL_BITS'((SAMPLE_BITS - 1) << OCT_FRAC);

	localparam int SHIFT_SAT  = 32;
	localparam int SHIFT_ZERO = 63;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_THRESHOLD   = 3'd0,
		REG_RATIO       = 3'd1,
		REG_INPUT_GAIN  = 3'd2,
		REG_MAKEUP_GAIN = 3'd3,
		REG_BYPASS      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [LVL_BITS-1:0] thr_oct;
		logic signed [LVL_BITS-1:0] gin_oct;
		logic signed [LVL_BITS-1:0] mk_oct;
		logic [RATIO_BITS-1:0]      ratio;
		logic                       bypass;
	} cfg_t;

	// per-request sideband that travels with the pipeline
	typedef struct packed {
		logic                   byp;
		logic                   zero;
		logic                   neg;
		logic                   comp;
		logic [SAMPLE_BITS-1:0] mag;
		logic [SAMPLE_BITS-1:0] raw;
	} smp_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^(2^-k) in q1.30, k from 1, each root taken from the previous one
	function automatic logic [MANT_BITS-1:0] exp2_const(input int k);
		logic [63:0] c;
		c = isqrt64(64'd2 << 60);
		for (int j = 1; j < LOG_TABLE_BITS; j++) begin
			if (j < k) c = isqrt64(c << MANT_FRAC);
		end
		return c[MANT_BITS-1:0];
	endfunction

endpackage

@@ rtl/hkac_cfg.sv @@
// ----------------------------------------------------------------------------
// hkac_cfg
// configuration registers, dB values held as q.16 octaves, ratio clamped
// ----------------------------------------------------------------------------
module hkac_cfg import hkac_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;
	logic [RATIO_BITS-1:0] ratio_c;
	logic signed [LVL_BITS-1:0] thr_c;
	logic signed [LVL_BITS-1:0] gain_c;

	function automatic logic signed [LVL_BITS-1:0] db_to_oct(
		input logic signed [THR_BITS-1:0] db);
		logic signed [THR_BITS+CONV_BITS-1:0] prod;
		prod = db * DB_TO_OCT;
		return prod[OCT_FRAC +: LVL_BITS];
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_comb begin
		ratio_c = cfg_data[RATIO_BITS-1:0];
		if (ratio_c < RATIO_MIN) ratio_c = RATIO_MIN;
		if (ratio_c > RATIO_MAX) ratio_c = RATIO_MAX;
		thr_c  = db_to_oct($signed(cfg_data[THR_BITS-1:0]));
		gain_c = db_to_oct(THR_BITS'($signed(cfg_data[GAIN_BITS-1:0])));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_oct <= '0;
			cfg_q.gin_oct <= '0;
			cfg_q.mk_oct  <= '0;
			cfg_q.ratio   <= RATIO_MIN;
			cfg_q.bypass  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD:   cfg_q.thr_oct <= thr_c;
				REG_RATIO:       cfg_q.ratio   <= ratio_c;
				REG_INPUT_GAIN:  cfg_q.gin_oct <= gain_c;
				REG_MAKEUP_GAIN: cfg_q.mk_oct  <= gain_c;
				REG_BYPASS:      cfg_q.bypass  <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/hkac_log2.sv @@
// ----------------------------------------------------------------------------
// hkac_log2
// log2 of the sample magnitude: leading one, then one squaring per stage
// ----------------------------------------------------------------------------
module hkac_log2 import hkac_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  smp_t                      in_smp,
	output logic                      out_valid,
	output smp_t                      out_smp,
	output logic [POS_BITS-1:0]       out_pos,
	output logic [LOG_TABLE_BITS-1:0] out_frac
);

	localparam int N = LOG_TABLE_BITS;

	logic                      v_s    [0:N];
	smp_t                      smp_s  [0:N];
	logic [POS_BITS-1:0]       pos_s  [0:N];
	logic [MANT_BITS-1:0]      mant_s [0:N];
	logic [LOG_TABLE_BITS-1:0] frac_s [0:N];

	logic [POS_BITS-1:0]  pos_c;
	logic [MANT_BITS-1:0] mant_c;

	// leading one and normalise to q1.30
	always_comb begin
		pos_c = '0;
		for (int i = 0; i < SAMPLE_BITS; i++) begin
			if (in_smp.mag[i]) pos_c = POS_BITS'(i);
		end
		mant_c = MANT_BITS'(in_smp.mag) << (MANT_BITS - 1 - int'(pos_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else         v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		smp_s[0]  <= in_smp;
		pos_s[0]  <= pos_c;
		mant_s[0] <= mant_c;
		frac_s[0] <= '0;
	end

	for (genvar k = 0; k < N; k++) begin : g_sq
		logic [2*MANT_BITS-1:0] prod;
		logic [MANT_BITS:0]     sq;

		assign prod = {{MANT_BITS{1'b0}}, mant_s[k]} * {{MANT_BITS{1'b0}}, mant_s[k]};
		assign sq   = prod[MANT_FRAC +: MANT_BITS+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else         v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			smp_s[k+1]  <= smp_s[k];
			pos_s[k+1]  <= pos_s[k];
			mant_s[k+1] <= sq[MANT_BITS] ? sq[MANT_BITS:1] : sq[MANT_BITS-1:0];
			frac_s[k+1] <= {frac_s[k][LOG_TABLE_BITS-2:0], sq[MANT_BITS]};
		end
	end

	assign out_valid = v_s[N];
	assign out_smp   = smp_s[N];
	assign out_pos   = pos_s[N];
	assign out_frac  = frac_s[N];

endmodule

@@ rtl/hkac_div.sv @@
// ----------------------------------------------------------------------------
// hkac_div
// pipelined restoring divider, two quotient bits per stage
// ----------------------------------------------------------------------------
module hkac_div import hkac_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  smp_t                       in_smp,
	input  logic signed [LVL_BITS-1:0] in_d,
	input  logic [DIV_BITS-1:0]        in_num,
	input  logic [RATIO_BITS-1:0]      ratio,
	output logic                       out_valid,
	output smp_t                       out_smp,
	output logic signed [LVL_BITS-1:0] out_d,
	output logic [DIV_BITS-1:0]        out_quot
);

	logic                       v_s    [0:DIV_STAGES];
	smp_t                       smp_s  [0:DIV_STAGES];
	logic signed [LVL_BITS-1:0] d_s    [0:DIV_STAGES];
	logic [DIV_BITS-1:0]        num_s  [0:DIV_STAGES];
	logic [DIV_BITS-1:0]        quot_s [0:DIV_STAGES];
	logic [RATIO_BITS-1:0]      rem_s  [0:DIV_STAGES];

	assign v_s[0]    = in_valid;
	assign smp_s[0]  = in_smp;
	assign d_s[0]    = in_d;
	assign num_s[0]  = in_num;
	assign quot_s[0] = '0;
	assign rem_s[0]  = '0;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [RATIO_BITS-1:0] rem_c;
		logic [DIV_BITS-1:0]   num_c;
		logic [DIV_BITS-1:0]   quot_c;

		always_comb begin : b_step
			logic [RATIO_BITS:0] t;
			rem_c  = rem_s[k];
			num_c  = num_s[k];
			quot_c = quot_s[k];
			for (int j = 0; j < DIV_STEP; j++) begin
				t     = {rem_c, num_c[DIV_BITS-1]};
				num_c = num_c << 1;
				if (t >= {1'b0, ratio}) begin
					t      = t - {1'b0, ratio};
					quot_c = {quot_c[DIV_BITS-2:0], 1'b1};
				end else begin
					quot_c = {quot_c[DIV_BITS-2:0], 1'b0};
				end
				rem_c = t[RATIO_BITS-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else         v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			smp_s[k+1]  <= smp_s[k];
			d_s[k+1]    <= d_s[k];
			num_s[k+1]  <= num_c;
			quot_s[k+1] <= quot_c;
			rem_s[k+1]  <= rem_c;
		end
	end

	assign out_valid = v_s[DIV_STAGES];
	assign out_smp   = smp_s[DIV_STAGES];
	assign out_d     = d_s[DIV_STAGES];
	assign out_quot  = quot_s[DIV_STAGES];

endmodule

@@ rtl/hkac_exp2.sv @@
// ----------------------------------------------------------------------------
// hkac_exp2
// fractional gain as a product of 2^(2^-k) roots, then scaling of the magnitude
// ----------------------------------------------------------------------------
module hkac_exp2 import hkac_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  smp_t                         in_smp,
	input  logic signed [SHIFT_BITS-1:0] in_shift,
	input  logic [LOG_TABLE_BITS-1:0]    in_fb,
	output logic                         out_valid,
	output smp_t                         out_smp,
	output logic signed [SHIFT_BITS-1:0] out_shift,
	output logic [SAMPLE_BITS:0]         out_y
);

	localparam int N = LOG_TABLE_BITS;

	logic                         v_s     [0:N+1];
	smp_t                         smp_s   [0:N+1];
	logic signed [SHIFT_BITS-1:0] shift_s [0:N+1];
	logic [LOG_TABLE_BITS-1:0]    fb_s    [0:N];
	logic [MANT_BITS-1:0]         mant_s  [0:N];
	logic [SAMPLE_BITS:0]         y_s;

	assign v_s[0]     = in_valid;
	assign smp_s[0]   = in_smp;
	assign shift_s[0] = in_shift;
	assign fb_s[0]    = in_fb;
	assign mant_s[0]  = MANT_BITS'(1) << MANT_FRAC;

	for (genvar k = 0; k < N; k++) begin : g_root
		localparam logic [MANT_BITS-1:0] ROOT = exp2_const(k + 1);
		logic [2*MANT_BITS-1:0] prod;

		assign prod = {{MANT_BITS{1'b0}}, mant_s[k]} * {{MANT_BITS{1'b0}}, ROOT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else         v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			smp_s[k+1]   <= smp_s[k];
			shift_s[k+1] <= shift_s[k];
			fb_s[k+1]    <= fb_s[k];
			mant_s[k+1]  <= fb_s[k][N-1-k] ? prod[MANT_FRAC +: MANT_BITS] : mant_s[k];
		end
	end

	// magnitude times mantissa, back to sample scale
	logic [SAMPLE_BITS+MANT_BITS-1:0] scale;
	assign scale = {{MANT_BITS{1'b0}}, smp_s[N].mag} *
		{{SAMPLE_BITS{1'b0}}, mant_s[N]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[N+1] <= 1'b0;
		else         v_s[N+1] <= v_s[N];
	end

	always_ff @(posedge clk) begin
		smp_s[N+1]   <= smp_s[N];
		shift_s[N+1] <= shift_s[N];
		y_s          <= scale[MANT_FRAC +: SAMPLE_BITS+1];
	end

	assign out_valid = v_s[N+1];
	assign out_smp   = smp_s[N+1];
	assign out_shift = shift_s[N+1];
	assign out_y     = y_s;

endmodule

@@ rtl/hard_knee_audio_compressor.sv @@
// ----------------------------------------------------------------------------
// hard_knee_audio_compressor
// hard knee dynamic range compressor on signed q1.15 samples
// ----------------------------------------------------------------------------
// usage
//  - a request is taken on every rising edge with start high and busy low;
//    busy is never raised, so a new sample may enter every cycle
//  - each result appears on sample_out, clipped and compressing for one
//    cycle with done high
//  - throughput is one sample per cycle; the pipe holds the 8 squaring
//    stages of the log unit, 13 divider stages (two quotient bits each),
//    8 root multiplier stages and the surrounding normalise, level, gain,
//    scale and output stages
//  - the receiver cannot stall: results are never held back
//  - configuration goes through cfg_valid/cfg_ready with cfg_index and
//    cfg_data; cfg_ready is always high, write only while no sample is in
//    flight
//  - reset clears the pipeline valid bits and sets threshold and gains to
//    0 dB, ratio to 1:1 and bypass off
// ----------------------------------------------------------------------------
module hard_knee_audio_compressor import hkac_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [SAMPLE_BITS-1:0]    sample_in,
	output logic                      done,
	output logic [SAMPLE_BITS-1:0]    sample_out,
	output logic                      clipped,
	output logic                      compressing,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t cfg;

	// no back-pressure anywhere in the pipe
	assign busy = 1'b0;

	hkac_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sign and magnitude of the incoming sample
	smp_t in_smp;
	always_comb begin
		in_smp.raw  = sample_in;
		in_smp.neg  = sample_in[SAMPLE_BITS-1];
		in_smp.mag  = sample_in[SAMPLE_BITS-1] ? (~sample_in + 1'b1) : sample_in;
		in_smp.zero = (sample_in == '0);
		in_smp.byp  = cfg.bypass;
		in_smp.comp = 1'b0;
	end

	// stages 1 to 9: log2 of the magnitude
	logic                      log_v;
	smp_t                      log_smp;
	logic [POS_BITS-1:0]       log_pos;
	logic [LOG_TABLE_BITS-1:0] log_frac;

	hkac_log2 u_log2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_smp    (in_smp),
		.out_valid (log_v),
		.out_smp   (log_smp),
		.out_pos   (log_pos),
		.out_frac  (log_frac)
	);

	// stage 10: level against threshold
	logic signed [LVL_BITS-1:0] lvl_c;
	logic signed [LVL_BITS-1:0] over_c;
	logic                       comp_c;
	smp_t                       lvl_smp_c;

	always_comb begin
		lvl_c  = $signed(LVL_BITS'({log_pos, log_frac,
			{(OCT_FRAC-LOG_TABLE_BITS){1'b0}}})) - LVL_OFFSET + cfg.gin_oct;
		over_c = lvl_c - cfg.thr_oct;
		comp_c = lvl_c > cfg.thr_oct;
		lvl_smp_c      = log_smp;
		lvl_smp_c.comp = comp_c && !log_smp.byp && !log_smp.zero;
	end

	logic                       v_s10;
	smp_t                       smp_s10;
	logic signed [LVL_BITS-1:0] d_s10;
	logic [DIV_BITS-1:0]        num_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else         v_s10 <= log_v;
	end

	always_ff @(posedge clk) begin
		smp_s10      <= lvl_smp_c;
		d_s10        <= over_c;
		// excess level times 16, ready for the divide by the ratio
		num_s10      <= comp_c ? (DIV_BITS'(over_c) << RATIO_SHIFT) : '0;
	end

	// stages 11 to 23: divide by the ratio
	logic                       div_v;
	smp_t                       div_smp;
	logic signed [LVL_BITS-1:0] div_d;
	logic [DIV_BITS-1:0]        div_quot;

	hkac_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s10),
		.in_smp    (smp_s10),
		.in_d      (d_s10),
		.in_num    (num_s10),
		.ratio     (cfg.ratio),
		.out_valid (div_v),
		.out_smp   (div_smp),
		.out_d     (div_d),
		.out_quot  (div_quot)
	);

	// stage 24: total gain in octaves, split into shift and fraction
	logic signed [LVL_BITS-1:0] red_c;
	logic signed [LVL_BITS-1:0] gain_c;

	always_comb begin
		red_c  = div_smp.comp ? ($signed(div_quot[LVL_BITS-1:0]) - div_d) : '0;
		gain_c = cfg.gin_oct + red_c + cfg.mk_oct;
	end

	logic                         v_s24;
	smp_t                         smp_s24;
	logic signed [SHIFT_BITS-1:0] shift_s24;
	logic [LOG_TABLE_BITS-1:0]    fb_s24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s24 <= 1'b0;
		else         v_s24 <= div_v;
	end

	always_ff @(posedge clk) begin
		smp_s24   <= div_smp;
		shift_s24 <= gain_c[LVL_BITS-1:OCT_FRAC];
		fb_s24    <= gain_c[OCT_FRAC-1 -: LOG_TABLE_BITS];
	end

	// stages 25 to 33: fractional gain and scaling
	logic                         exp_v;
	smp_t                         exp_smp;
	logic signed [SHIFT_BITS-1:0] exp_shift;
	logic [SAMPLE_BITS:0]         exp_y;

	hkac_exp2 u_exp2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s24),
		.in_smp    (smp_s24),
		.in_shift  (shift_s24),
		.in_fb     (fb_s24),
		.out_valid (exp_v),
		.out_smp   (exp_smp),
		.out_shift (exp_shift),
		.out_y     (exp_y)
	);

	// stage 34: whole octave shift, saturation and sign
	logic [SAMPLE_BITS:0]   lim_c;
	logic [SAMPLE_BITS:0]   ysat_c;
	logic [SAMPLE_BITS:0]   yfin_c;
	logic [SHIFT_BITS-1:0]  nneg_c;
	logic                   clip_c;
	logic [SAMPLE_BITS-1:0] res_c;

	always_comb begin
		// full scale: 2^15 for negative results, 2^15-1 for positive ones
		lim_c  = {1'b0, exp_smp.neg, {(SAMPLE_BITS-1){~exp_smp.neg}}};
		nneg_c = -exp_shift;
		ysat_c = '0;
		if (!exp_shift[SHIFT_BITS-1]) begin
			if (int'(exp_shift) >= SHIFT_SAT || exp_y > (lim_c >> exp_shift)) begin
				ysat_c = lim_c + 1'b1;
			end else begin
				ysat_c = exp_y << exp_shift;
			end
		end else if (int'(nneg_c) < SHIFT_ZERO) begin
			ysat_c = exp_y >> nneg_c;
		end
		clip_c = ysat_c > lim_c;
		yfin_c = clip_c ? lim_c : ysat_c;
		res_c  = exp_smp.neg ? (~yfin_c[SAMPLE_BITS-1:0] + 1'b1) : yfin_c[SAMPLE_BITS-1:0];
	end

	logic                   done_s34;
	logic [SAMPLE_BITS-1:0] out_s34;
	logic                   clip_s34;
	logic                   comp_s34;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_s34 <= 1'b0;
		else         done_s34 <= exp_v;
	end

	always_ff @(posedge clk) begin
		if (exp_smp.byp) begin
			// bypass: sample untouched, no flags
			out_s34  <= exp_smp.raw;
			clip_s34 <= 1'b0;
			comp_s34 <= 1'b0;
		end else if (exp_smp.zero) begin
			out_s34  <= '0;
			clip_s34 <= 1'b0;
			comp_s34 <= 1'b0;
		end else begin
			out_s34  <= res_c;
			clip_s34 <= clip_c;
			comp_s34 <= exp_smp.comp;
		end
	end

	assign done        = done_s34;
	assign sample_out  = out_s34;
	assign clipped     = clip_s34;
	assign compressing = comp_s34;

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hard knee compressor: each accepted sample is
// run through a bit-exact fixed point model of the gain computer, and every
// result strobe is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;
	import hkac_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 4000;   // cycles with no handshake before giving up
	localparam int DRAIN_WAIT  = 40;     // a little over the pipeline latency
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   clip;
		logic                   comp;
	} comp_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [SAMPLE_BITS-1:0]    sample_in;
	logic                      done;
	logic [SAMPLE_BITS-1:0]    sample_out;
	logic                      clipped;
	logic                      compressing;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	// shadow copy of the register file, as the block should hold it
	logic [15:0] thr_reg;
	logic [9:0]  ratio_reg;
	logic [13:0] gin_reg;
	logic [13:0] mk_reg;
	logic        bypass_reg;

	comp_result_t     pending_results[$];
	longint unsigned  root_const[1:LOG_TABLE_BITS];
	int               mismatches;
	int               quiet_cycles;
	int               gap_max;

	hard_knee_audio_compressor dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.sample_in   (sample_in),
		.done        (done),
		.sample_out  (sample_out),
		.clipped     (clipped),
		.compressing (compressing),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------------
	// fixed point model
	// ------------------------------------------------------------------------
	function automatic longint unsigned int_sqrt(longint unsigned v_in);
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		v = v_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 1/256 dB to q.16 octaves, rounded towards minus infinity
	function automatic longint db_to_octaves(longint db);
		return (db * 64'sd2786635) >>> 16;
	endfunction

	function automatic comp_result_t compress_sample(logic [SAMPLE_BITS-1:0] raw);
		comp_result_t    res;
		longint          x;
		longint          lvl;
		longint          gin_oct;
		longint          thr_oct;
		longint          mk_oct;
		longint          knee_gain;
		longint          total;
		longint          whole;
		longint          ratio;
		longint          over;
		longint unsigned mag;
		longint unsigned mant;
		longint unsigned frac;
		longint unsigned lin;
		longint unsigned y;
		longint unsigned lim;
		int              msb;
		logic            neg;
		res.sample = '0;
		res.clip   = 1'b0;
		res.comp   = 1'b0;
		if (bypass_reg) begin
			res.sample = raw;
			return res;
		end
		x = longint'($signed(raw));
		if (x == 0) return res;

		neg     = x < 0;
		mag     = neg ? longint'(-x) : longint'(x);
		gin_oct = db_to_octaves(longint'($signed(gin_reg)));
		thr_oct = db_to_octaves(longint'($signed(thr_reg)));
		mk_oct  = db_to_octaves(longint'($signed(mk_reg)));
		ratio   = longint'(ratio_reg);
		if (ratio < 16) ratio = 16;
		if (ratio > 512) ratio = 512;

		// level: leading one position plus squared-mantissa fraction bits
		msb = 0;
		for (int i = 0; i < 32; i++) if (mag[i]) msb = i;
		mant = mag << (30 - msb);
		frac = 0;
		for (int k = 0; k < LOG_TABLE_BITS; k++) begin
			mant = (mant * mant) >> 30;
			frac = frac << 1;
			if (mant >= (64'd1 << 31)) begin
				frac = frac | 1;
				mant = mant >> 1;
			end
		end
		lvl = (longint'(msb) << 16) + longint'(frac << (16 - LOG_TABLE_BITS))
			- (longint'(SAMPLE_BITS - 1) << 16) + gin_oct;

		knee_gain = 0;
		if (lvl > thr_oct) begin
			over      = lvl - thr_oct;
			res.comp  = 1'b1;
			knee_gain = (over * 16) / ratio - over;
		end

		// gain back to linear: integer octaves as a shift, fraction from roots
		total = gin_oct + knee_gain + mk_oct;
		whole = total >>> 16;
		frac  = longint'(total - (whole << 16)) >> (16 - LOG_TABLE_BITS);
		lin   = 64'd1 << 30;
		for (int k = 1; k <= LOG_TABLE_BITS; k++) begin
			if (frac[LOG_TABLE_BITS-k]) lin = (lin * root_const[k]) >> 30;
		end
		y   = (mag * lin) >> 30;
		lim = neg ? (64'd1 << (SAMPLE_BITS - 1)) : (64'd1 << (SAMPLE_BITS - 1)) - 1;
		if (whole >= 0) begin
			if (whole >= 32 || y > (lim >> whole)) y = lim + 1;
			else y = y << whole;
		end else begin
			y = (whole <= -63) ? 0 : (y >> (-whole));
		end
		if (y > lim) begin
			y        = lim;
			res.clip = 1'b1;
		end
		res.sample = neg ? SAMPLE_BITS'(-y) : SAMPLE_BITS'(y);
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// result checker and watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		comp_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: sample %h clipped %b compressing %b",
						sample_out, clipped, compressing);
			end else begin
				want = pending_results.pop_front();
				if (sample_out !== want.sample || clipped !== want.clip ||
						compressing !== want.comp) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: expected %h/%b/%b got %h/%b/%b",
							want.sample, want.clip, want.comp,
							sample_out, clipped, compressing);
				end
			end
		end
	end

	// any handshake on either port counts as progress
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// shared drivers
	// ------------------------------------------------------------------------
	task automatic send_sample(logic [SAMPLE_BITS-1:0] value);
		int gap;
		gap = $urandom_range(gap_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		sample_in <= value;
		do @(posedge clk); while (busy);
		pending_results.push_back(compress_sample(value));
	endtask

	// sender holds off until every outstanding result is back
	task automatic drain;
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// writes all five registers back to back, only ever with the block idle
	task automatic apply_settings(logic [15:0] thr, logic [9:0] ratio,
			logic [13:0] gin, logic [13:0] mk, logic byp);
		logic [15:0] vals[5];
		cfg_reg_t    regs[5];
		drain();
		regs = '{REG_THRESHOLD, REG_RATIO, REG_INPUT_GAIN, REG_MAKEUP_GAIN, REG_BYPASS};
		vals = '{thr, 16'(ratio), 16'(gin), 16'(mk), 16'(byp)};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid  <= 1'b0;
		thr_reg    = thr;
		ratio_reg  = ratio;
		gin_reg    = gin;
		mk_reg     = mk;
		bypass_reg = byp;
	endtask

	// mostly full range, often small magnitudes to work the low octaves
	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		logic [SAMPLE_BITS-1:0] s;
		s = SAMPLE_BITS'($urandom);
		if ($urandom_range(2) == 0) s = SAMPLE_BITS'($signed(s) >>> $urandom_range(15));
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic send_edge_samples;
		logic [SAMPLE_BITS-1:0] edges[10];
		edges = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000,
			16'h4000, 16'hc000, 16'h00ff, 16'hff01, 16'h5a5a};
		foreach (edges[i]) send_sample(edges[i]);
	endtask

	// reset settings: unity ratio, 0 dB everywhere
	task automatic test_reset_defaults;
		gap_max = 0;
		send_edge_samples();
	endtask

	task automatic test_bypass;
		apply_settings(16'hc000, 10'd512, 14'd6144, -14'sd6144, 1'b1);
		send_edge_samples();
	endtask

	// ratio clamping at both ends, plus gains well past full scale
	task automatic test_ratio_and_gain_extremes;
		gap_max = 12;
		apply_settings(-16'sd24576, 10'd0, 14'd6144, 14'd6144, 1'b0);
		send_edge_samples();
		apply_settings(16'sd0, 10'd1023, -14'sd6144, 14'd0, 1'b0);
		send_edge_samples();
		// a ratio below the minimum is clamped, the other extreme values are taken as given
		apply_settings(16'h7fff, 10'd15, 14'h1fff, 14'h2000, 1'b0);
		send_edge_samples();
	endtask

	task automatic test_random_settings(int phases, int per_phase);
		logic [15:0] thr;
		logic [9:0]  ratio;
		logic [13:0] gin;
		logic [13:0] mk;
		for (int ph = 0; ph < phases; ph++) begin
			case ($urandom_range(3))
				0: thr = 16'sd0;
				1: thr = -16'sd24576;
				default: thr = 16'(-int'($urandom_range(24576)));
			endcase
			case ($urandom_range(5))
				0: ratio = 10'd16;
				1: ratio = 10'd512;
				2: ratio = 10'($urandom);
				default: ratio = 10'($urandom_range(512, 16));
			endcase
			gin = 14'(int'($urandom_range(12288)) - 6144);
			mk  = 14'(int'($urandom_range(12288)) - 6144);
			apply_settings(thr, ratio, gin, mk, $urandom_range(7) == 0);
			// every third phase back-to-back, the others bursty
			gap_max = (ph % 3 == 0) ? 0 : 12;
			for (int i = 0; i < per_phase; i++) begin
				send_sample(random_sample());
				// sender pause long enough for the pipeline to empty
				if (i == per_phase / 2 && ph == 1) drain();
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		sample_in  = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_THRESHOLD;
		cfg_data   = '0;
		mismatches = 0;
		quiet_cycles = 0;
		gap_max    = 0;
		thr_reg    = '0;
		ratio_reg  = 10'd16;
		gin_reg    = '0;
		mk_reg     = '0;
		bypass_reg = 1'b0;
		root_const[1] = int_sqrt(64'd2 << 60);
		for (int k = 2; k <= LOG_TABLE_BITS; k++)
			root_const[k] = int_sqrt(root_const[k-1] << 30);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_bypass();
		test_ratio_and_gain_extremes();
		test_random_settings(10, 130);

		drain();
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
